// ===== rtl/trp_pkg.sv =====
// ----------------------------------------------------------------------------
// trp_pkg: shared types and constants of the telemetry record parser
// Register map, group codes, record geometry and the single-precision halver.
// ----------------------------------------------------------------------------
package trp_pkg;

   localparam int unsigned NumGroups         = 7;
   localparam int unsigned RecBytes          = 36;
   localparam int unsigned RecStart          = 5;
   localparam int unsigned DefMaxPacketBytes = 300;
   localparam int unsigned CsrAddrWidth      = 5;

   localparam logic [7:0] CharD = 8'h44;
   localparam logic [7:0] CharA = 8'h41;
   localparam logic [7:0] CharT = 8'h54;

   typedef enum logic [2:0] {
      GRP_ATTITUDE = 3'd0,
      GRP_RATES    = 3'd1,
      GRP_LOAD     = 3'd2,
      GRP_POSITION = 3'd3,
      GRP_COMMAND  = 3'd4,
      GRP_THROTTLE = 3'd5,
      GRP_SPEED    = 3'd6
   } group_type;

   typedef enum logic [2:0] {
      REG_ATTITUDE = 3'd0,
      REG_RATES    = 3'd1,
      REG_LOAD     = 3'd2,
      REG_POSITION = 3'd3,
      REG_COMMAND  = 3'd4,
      REG_THROTTLE = 3'd5,
      REG_SPEED    = 3'd6
   } reg_type;

   localparam logic [7:0] CfgReset [NumGroups] = '{8'd17, 8'd16, 8'd4, 8'd20, 8'd8, 8'd25, 8'd3};

   // A completed record handed from the front to the back.
   typedef struct packed {
      group_type   grp;
      logic [31:0] value_a;
      logic [31:0] value_b;
      logic [31:0] value_c;
   } rec_type;

   // Exact halving of an IEEE single, round to nearest even into subnormals.
   function automatic logic [31:0] half_single(input logic [31:0] x);
      logic [7:0]  ex;
      logic [22:0] fr;
      logic [23:0] m;
      logic [23:0] r;
      ex = x[30:23];
      fr = x[22:0];
      m  = {(ex == 8'd1), fr};
      r  = {1'b0, m[23:1]};
      if (m[0] && r[0]) begin
         r = r + 24'd1;
      end
      if (ex == 8'hFF) begin
         half_single = (fr != 23'd0) ? (x | 32'h0040_0000) : x;
      end else if (ex >= 8'd2) begin
         half_single = {x[31], ex - 8'd1, fr};
      end else begin
         half_single = {x[31], 8'd0, 23'd0} | {8'd0, r};
      end
   endfunction

endpackage

// ===== rtl/trp_if.sv =====
// ----------------------------------------------------------------------------
// trp_if: valid/ready channel
// Generic handshake channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface trp_if #(parameter type PayloadType = logic [7:0]);
   logic       valid;
   logic       ready;
   PayloadType data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/trp_front.sv =====
// ----------------------------------------------------------------------------
// trp_front: byte parser
// Tracks packet position, checks the header, gathers record words and
// classifies each completed record into a group with its selected words.
// ----------------------------------------------------------------------------
module trp_front
   import trp_pkg::*;
#(
   parameter int unsigned MaxPacketBytes = DefMaxPacketBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [7:0]  in_byte,
   input  logic        in_last,
   input  logic [7:0]  cfg_idx [NumGroups],
   output logic        rec_valid,
   output rec_type     rec_data
);

   localparam int unsigned PosWidth = $clog2(MaxPacketBytes + 1);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic                hdr_ff, hdr_in;
   logic [5:0]          off_ff, off_in;
   logic [31:0]         idx_ff, idx_in;
   logic [31:0]         words_ff [8];
   logic                active;
   logic                hdr_ok;
   logic                done;
   logic [NumGroups-1:0] hit;
   logic [2:0]          g;
   logic                any_hit;
   logic [31:0]         v [8];

   assign active = in_valid && (pos_ff < PosWidth'(MaxPacketBytes));

   // Header character expected at this position.
   always_comb begin
      unique case (pos_ff[1:0])
         2'd0:    hdr_ok = (in_byte == CharD);
         2'd2:    hdr_ok = (in_byte == CharT);
         default: hdr_ok = (in_byte == CharA);
      endcase
   end

   // Position, header flag and record offset.
   always_comb begin
      pos_in = pos_ff;
      hdr_in = hdr_ff;
      off_in = off_ff;
      if (active) begin
         pos_in = pos_ff + PosWidth'(1);
         if (pos_ff < PosWidth'(4)) begin
            hdr_in = (pos_ff == '0) ? hdr_ok : (hdr_ff && hdr_ok);
            off_in = '0;
         end else if (pos_ff >= PosWidth'(RecStart)) begin
            off_in = (off_ff == 6'(RecBytes - 1)) ? 6'd0 : off_ff + 6'd1;
         end
      end
      if (in_valid && in_last) begin
         pos_in = '0;
         hdr_in = 1'b0;
         off_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         hdr_ff <= 1'b0;
         off_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         hdr_ff <= hdr_in;
         off_ff <= off_in;
      end
   end

   // Record byte capture.
   always_comb begin
      idx_in = idx_ff;
      if (active && pos_ff >= PosWidth'(RecStart) && off_ff < 6'd4) begin
         idx_in[off_ff[1:0]*8 +: 8] = in_byte;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (active && pos_ff >= PosWidth'(RecStart) && off_ff >= 6'd4) begin
         words_ff[3'((off_ff - 6'd4) >> 2)][off_ff[1:0]*8 +: 8] <= in_byte;
      end
   end

   // Current record words with this beat's byte merged in.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         v[i] = words_ff[i];
      end
      v[7][31:24] = in_byte;
   end

   assign done = active && pos_ff >= PosWidth'(RecStart)
                 && off_ff == 6'(RecBytes - 1) && hdr_ff;

   // Priority match against the configured indices.
   always_comb begin
      for (int i = 0; i < NumGroups; i++) begin
         hit[i] = (idx_ff == {24'd0, cfg_idx[i]});
      end
      any_hit = |hit;
      g = 3'd0;
      for (int i = NumGroups - 1; i >= 0; i--) begin
         if (hit[i]) begin
            g = 3'(i);
         end
      end
   end

   // Word selection per group.
   always_comb begin
      rec_data.grp     = group_type'(g);
      rec_data.value_a = v[0];
      rec_data.value_b = v[1];
      rec_data.value_c = v[2];
      unique case (group_type'(g))
         GRP_RATES: begin
            rec_data.value_a = v[1];
            rec_data.value_b = v[0];
         end
         GRP_LOAD: begin
            rec_data.value_a = v[4];
            rec_data.value_b = v[5];
            rec_data.value_c = v[6];
         end
         GRP_THROTTLE: begin
            rec_data.value_b = '0;
            rec_data.value_c = '0;
         end
         GRP_SPEED: begin
            rec_data.value_a = half_single(v[3]);
            rec_data.value_b = '0;
            rec_data.value_c = '0;
         end
         default: ;
      endcase
   end

   assign rec_valid = done && any_hit;

endmodule

// ===== rtl/trp_back.sv =====
// ----------------------------------------------------------------------------
// trp_back: record queue and result stage
// Buffers classified records, bumps the group counter and drives results.
// ----------------------------------------------------------------------------
module trp_back
   import trp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        rec_valid,
   input  rec_type     rec_data,
   output logic        rec_ready,
   trp_if.source       rsp
);

   logic [1:0]  cnt_ff, cnt_in;
   logic        rd_ff, rd_in;
   logic        wr_ff, wr_in;
   rec_type     q_ff [2];
   logic [31:0] ctr_ff [NumGroups];
   logic        pop;
   rec_type     head;
   logic [31:0] next_ctr;

   // The front is held off while both slots are taken, so a record is never dropped.
   assign rec_ready = (cnt_ff != 2'd2);
   assign head      = q_ff[rd_ff];
   assign pop       = (cnt_ff != 2'd0) && rsp.ready;
   assign next_ctr  = ctr_ff[head.grp] + 32'd1;
   assign rsp.valid = (cnt_ff != 2'd0);
   assign rsp.data  = {head.grp, head.value_a, head.value_b, head.value_c, next_ctr};

   always_comb begin
      cnt_in = cnt_ff + 2'(rec_valid) - 2'(pop);
      wr_in  = rec_valid ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         for (int i = 0; i < NumGroups; i++) begin
            ctr_ff[i] <= '0;
         end
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         if (pop) begin
            ctr_ff[head.grp] <= next_ctr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rec_valid) begin
         q_ff[wr_ff] <= rec_data;
      end
   end

endmodule

// ===== rtl/telemetry_record_parser.sv =====
// ----------------------------------------------------------------------------
// telemetry_record_parser: top level
// Parses DATA telemetry packets byte by byte and reports matching records.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat
// req       in         data_byte, last_byte
// rsp       out        group, value_a, value_b, value_c, update_count
// csr       in         APB register writes and reads
//
// One byte is taken every clock while the record queue has a free slot.
// A matching record enters the record queue as its last byte is accepted; its result is driven from the queue head.
// The two-entry record queue absorbs rsp stalls; when both slots hold records,
// req.ready drops until a result beat leaves.
// Reset is synchronous and clears position, header state and counters.
// ----------------------------------------------------------------------------
module telemetry_record_parser
   import trp_pkg::*;
#(
   parameter int unsigned MaxPacketBytes = DefMaxPacketBytes
) (
   input  logic                    clock,
   input  logic                    reset,
   trp_if.sink                     req,
   trp_if.source                   rsp,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   logic [7:0] cfg_ff [NumGroups];
   logic       rec_valid;
   rec_type    rec_data;
   logic       rec_ready;
   logic [2:0] reg_sel;

   assign req.ready  = rec_ready;
   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[4:2];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumGroups; i++) begin
            cfg_ff[i] <= CfgReset[i];
         end
      end else if (csr_psel && csr_penable && csr_pwrite && reg_sel < 3'(NumGroups)) begin
         cfg_ff[reg_sel] <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_sel < 3'(NumGroups)) begin
         csr_prdata = {24'd0, cfg_ff[reg_sel]};
      end
   end

   trp_front #(.MaxPacketBytes(MaxPacketBytes)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid && req.ready),
      .in_byte   (req.data[8:1]),
      .in_last   (req.data[0]),
      .cfg_idx   (cfg_ff),
      .rec_valid (rec_valid),
      .rec_data  (rec_data)
   );

   trp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (rec_valid),
      .rec_data  (rec_data),
      .rec_ready (rec_ready),
      .rsp       (rsp)
   );

endmodule

// ===== tb/trp_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_tb_if: beat layouts of the parser channels
// Packed payload types that the testbench hands to the channel interface.
// ----------------------------------------------------------------------------
package trp_tb_pkg;
   import trp_pkg::*;

   // One packet byte with its end-of-packet flag.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } byte_beat_t;

   // One reported record.
   typedef struct packed {
      group_type   group;
      logic [31:0] value_a;
      logic [31:0] value_b;
      logic [31:0] value_c;
      logic [31:0] update_count;
   } record_beat_t;
endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: telemetry record parser check
// Feeds DATA and non-DATA packets byte by byte under changing register
// settings and idle patterns, predicts each reported record and compares it.
// ----------------------------------------------------------------------------
module testbench;
   import trp_pkg::*;
   import trp_tb_pkg::*;

   localparam int MaxBytes = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0]             csr_pwdata = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   trp_if #(.PayloadType(byte_beat_t))   req_ch ();
   trp_if #(.PayloadType(record_beat_t)) rsp_ch ();

   telemetry_record_parser dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // Clock with a period of 8 ns.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   byte_beat_t   pending_bytes[$];
   record_beat_t expected_records[$];
   int           fail_count = 0;
   int           records_predicted = 0;
   int           bytes_sent = 0;
   int           sender_idle_pct = 0;
   int           receiver_stall_pct = 0;

   // Parser image kept by the testbench.
   logic [7:0]  index_cfg[NumGroups];
   int          pkt_pos;
   bit          hdr_ok;
   logic [31:0] rec_index;
   logic [31:0] rec_words[8];
   logic [31:0] group_count[NumGroups];

   // Exact halving of a single-precision bit pattern.
   function automatic logic [31:0] halve_float(input logic [31:0] x);
      logic [7:0]  ex;
      logic [23:0] mant;
      logic [23:0] shifted;
      ex = x[30:23];
      if (ex == 8'hFF) begin
         return (x[22:0] != 0) ? (x | 32'h0040_0000) : x;
      end
      if (ex >= 8'd2) begin
         return {x[31], ex - 8'd1, x[22:0]};
      end
      mant = {ex == 8'd1, x[22:0]};
      shifted = mant >> 1;
      if (mant[0] && shifted[0]) begin
         shifted = shifted + 1;
      end
      return {x[31], 31'(shifted)};
   endfunction

   // Advance the parser image by one accepted byte.
   function automatic void parse_byte(input byte_beat_t beat);
      int           off;
      int           sh;
      int           g;
      record_beat_t rec;
      if (pkt_pos < MaxBytes) begin
         if (pkt_pos < 4) begin
            bit ok;
            ok = (beat.data_byte == ((pkt_pos == 0) ? CharD :
                  (pkt_pos == 2) ? CharT : CharA));
            hdr_ok = (pkt_pos == 0) ? ok : (hdr_ok && ok);
         end else if (pkt_pos >= RecStart) begin
            off = (pkt_pos - RecStart) % RecBytes;
            sh = (off % 4) * 8;
            if (off < 4) begin
               rec_index[sh +: 8] = beat.data_byte;
            end else begin
               rec_words[(off - 4) / 4][sh +: 8] = beat.data_byte;
            end
            if (off == RecBytes - 1 && hdr_ok) begin
               g = NumGroups;
               for (int i = NumGroups - 1; i >= 0; i--) begin
                  if (rec_index == {24'd0, index_cfg[i]}) g = i;
               end
               if (g < NumGroups) begin
                  rec.group = group_type'(g);
                  rec.value_b = '0;
                  rec.value_c = '0;
                  case (group_type'(g))
                     GRP_RATES: begin
                        rec.value_a = rec_words[1];
                        rec.value_b = rec_words[0];
                        rec.value_c = rec_words[2];
                     end
                     GRP_LOAD: begin
                        rec.value_a = rec_words[4];
                        rec.value_b = rec_words[5];
                        rec.value_c = rec_words[6];
                     end
                     GRP_THROTTLE: rec.value_a = rec_words[0];
                     GRP_SPEED: rec.value_a = halve_float(rec_words[3]);
                     default: begin
                        rec.value_a = rec_words[0];
                        rec.value_b = rec_words[1];
                        rec.value_c = rec_words[2];
                     end
                  endcase
                  group_count[g] = group_count[g] + 1;
                  rec.update_count = group_count[g];
                  expected_records.push_back(rec);
                  records_predicted++;
               end
            end
         end
         pkt_pos++;
      end
      if (beat.last_byte) begin
         pkt_pos = 0;
         hdr_ok = 0;
      end
   endfunction

   // Driver: one nonblocking update of valid per edge.
   always @(posedge clock) begin
      logic       next_valid;
      byte_beat_t next_beat;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else begin
         next_valid = req_ch.valid;
         next_beat = req_ch.data;
         if (req_ch.valid && req_ch.ready) begin
            parse_byte(req_ch.data);
            void'(pending_bytes.pop_front());
            bytes_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_bytes.size() > 0 &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            next_valid = 1'b1;
            next_beat = pending_bytes[0];
         end
         req_ch.valid <= next_valid;
         req_ch.data <= next_beat;
      end
   end

   // Monitor: compare each record beat with the oldest prediction.
   always @(posedge clock) begin
      record_beat_t want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_records.size() == 0) begin
               $error("record beat with none predicted: group %0d", rsp_ch.data.group);
               fail_count++;
            end else begin
               want = expected_records.pop_front();
               if (rsp_ch.data.group !== want.group) begin
                  $error("group: expected %0d, got %0d", want.group, rsp_ch.data.group);
                  fail_count++;
               end
               if (rsp_ch.data.value_a !== want.value_a) begin
                  $error("value_a: expected %h, got %h", want.value_a, rsp_ch.data.value_a);
                  fail_count++;
               end
               if (rsp_ch.data.value_b !== want.value_b) begin
                  $error("value_b: expected %h, got %h", want.value_b, rsp_ch.data.value_b);
                  fail_count++;
               end
               if (rsp_ch.data.value_c !== want.value_c) begin
                  $error("value_c: expected %h, got %h", want.value_c, rsp_ch.data.value_c);
                  fail_count++;
               end
               if (rsp_ch.data.update_count !== want.update_count) begin
                  $error("update_count: expected %0d, got %0d",
                         want.update_count, rsp_ch.data.update_count);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Register write over the APB port, setup then access.
   task automatic write_index(input reg_type which, input logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CsrAddrWidth'(4 * int'(which));
      csr_pwdata <= {$urandom_range(0, 1) ? 24'($urandom) : 24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      index_cfg[which] = value;
   endtask

   // Float pattern that often lands on the halving corner cases.
   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 7))
         0: w[30:23] = 8'h00;
         1: w[30:23] = 8'h01;
         2: w[30:23] = 8'h02;
         3: w[30:23] = 8'hFF;
         4: w[30:0] = $urandom_range(0, 1) ? 31'h7F80_0000 : 31'd0;
         default: ;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] pick_index();
      logic [31:0] idx;
      int          pick;
      pick = $urandom_range(0, 9);
      idx = {24'd0, index_cfg[$urandom_range(0, NumGroups - 1)]};
      if (pick == 7) idx = $urandom;
      if (pick == 8) idx[31:8] = 24'($urandom_range(1, 24'hFFFFFF));
      if (pick == 9) idx = $urandom_range(0, 255);
      return idx;
   endfunction

   function automatic void push_byte(input logic [7:0] b, input bit last);
      byte_beat_t beat;
      beat.data_byte = b;
      beat.last_byte = last;
      pending_bytes.push_back(beat);
   endfunction

   // Queue one packet: header, pad byte, records and a trailing fragment.
   function automatic void queue_packet(input bit good_hdr, input int nrec, input int tail);
      logic [7:0]  bytes[$];
      logic [31:0] word;
      int          bad;
      bytes = '{CharD, CharA, CharT, CharA, 8'($urandom)};
      if (!good_hdr) begin
         bad = $urandom_range(0, 3);
         bytes[bad] = bytes[bad] ^ 8'($urandom_range(1, 255));
      end
      for (int r = 0; r < nrec; r++) begin
         for (int w = 0; w < 9; w++) begin
            word = (w == 0) ? pick_index() : pick_word();
            for (int k = 0; k < 4; k++) bytes.push_back(word[8*k +: 8]);
         end
      end
      for (int k = 0; k < tail; k++) bytes.push_back(8'($urandom));
      foreach (bytes[i]) push_byte(bytes[i], i == bytes.size() - 1);
   endfunction

   task automatic drain();
      while (pending_bytes.size() > 0 || expected_records.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Stimulus, phase by phase.
   initial begin
      int phase;
      for (int i = 0; i < NumGroups; i++) begin
         index_cfg[i] = CfgReset[i];
         group_count[i] = '0;
      end
      pkt_pos = 0;
      hdr_ok = 0;
      rec_index = '0;
      foreach (rec_words[i]) rec_words[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: defaults, one good record, a bad header, a lone last byte.
      queue_packet(1'b1, 1, 0);
      queue_packet(1'b0, 1, 0);
      push_byte(8'hFF, 1'b1);
      drain();

      // Directed: distinct indices for all groups, then three records and a trailing fragment.
      for (int g = 0; g < NumGroups; g++) write_index(reg_type'(g), 8'(10 + g));
      queue_packet(1'b1, 3, 7);
      drain();

      // Run every idle pattern at least once.
      phase = 0;
      while (phase < 4 || bytes_sent < 1500 || records_predicted < 60) begin
         sender_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? ((phase % 4 == 1) ? 50 : 21) : 0;
         receiver_stall_pct = (phase % 4 == 2) ? 50 : ((phase % 4 == 3) ? 21 : 0);
         case (phase % 5)
            0: for (int g = 0; g < NumGroups; g++) write_index(reg_type'(g), 8'd0);
            1: for (int g = 0; g < NumGroups; g++) write_index(reg_type'(g), 8'd255);
            default:
               for (int g = 0; g < NumGroups; g++) write_index(reg_type'(g), 8'($urandom));
         endcase
         for (int p = 0; p < 4; p++) begin
            int sel;
            sel = $urandom_range(0, 19);
            if (sel == 0) queue_packet(1'b1, 8 + $urandom_range(0, 1), $urandom_range(0, 40));
            else if (sel == 1) queue_packet(1'b0, $urandom_range(0, 3), $urandom_range(0, 35));
            else if (sel == 2) begin
               for (int k = $urandom_range(1, 4); k > 0; k--) push_byte(8'($urandom), k == 1);
            end else queue_packet(1'b1, $urandom_range(1, 3),
                                  $urandom_range(0, 3) == 0 ? $urandom_range(1, 35) : 0);
         end
         drain();
         phase++;
      end

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Guard against a hung run.
   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== telemetry_record_parser.f =====
rtl/trp_pkg.sv
rtl/trp_if.sv
rtl/trp_front.sv
rtl/trp_back.sv
rtl/telemetry_record_parser.sv
tb/trp_tb_if.sv
tb/testbench.sv
